>>> hdl/hbs_pkg.sv
`default_nettype none
package hbs_pkg;
  localparam int unsigned FracW = 16;
  localparam int unsigned CellLenW = 16;
  localparam int unsigned CellLenReset = 2565;
  localparam int unsigned GridSize = 512;

  typedef enum logic [1:0] {
    REG_ORIGIN_X = 2'd0,
    REG_ORIGIN_Z = 2'd1,
    REG_CELL_LEN = 2'd2
  } reg_idx_e;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  typedef struct packed {
    logic               action;
    logic [8:0]         grid_row;
    logic [8:0]         grid_col;
    logic [7:0]         height_value;
    logic signed [31:0] world_x;
    logic signed [31:0] world_z;
  } req_t;

  typedef struct packed {
    logic [15:0] terrain_height;
    logic        on_terrain;
  } rsp_t;
endpackage
`default_nettype wire

>>> hdl/hbs_ram.sv
`default_nettype none
module hbs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

>>> hdl/hbs_divider.sv
`default_nettype none
// pipelined restoring divider: one quotient bit per stage
// computes q = floor(num/den) (num width NumW) and the Q0.16 fraction of the remainder
module hbs_divider #(
  parameter int unsigned NumW = 33,
  parameter int unsigned TagW = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic [NumW-1:0]      num_i,
  input  wire logic [15:0]          den_i,
  input  wire logic [TagW-1:0]      tag_i,
  output logic      [NumW-1:0]      quot_o,
  output logic      [15:0]          frac_o,
  output logic      [TagW-1:0]      tag_o
);
  localparam int unsigned Steps = NumW + 16;
  localparam int unsigned DivW = Steps;

  // dividend extended by 16 zero bits, quotient bits shift in at the bottom
  logic [DivW-1:0] val_q [Steps+1];
  logic [16:0]     rem_q [Steps+1];
  logic [15:0]     den_q [Steps+1];
  logic [TagW-1:0] tag_q [Steps+1];

  always_comb begin
    val_q[0] = {num_i, 16'd0};
    rem_q[0] = '0;
    den_q[0] = den_i;
    tag_q[0] = tag_i;
  end

  for (genvar s = 0; s < Steps; s++) begin : g_stage
    logic [17:0] trial;
    logic        ge;
    logic [16:0] rem_d;
    logic [16:0] rem_s;
    logic [DivW-1:0] val_d;
    always_comb begin
      trial = {rem_q[s], val_q[s][DivW-1]};
      ge    = trial >= {2'b00, den_q[s]};
      rem_s = trial[16:0] - {1'b0, den_q[s]};
      rem_d = ge ? rem_s : trial[16:0];
      val_d = {val_q[s][DivW-2:0], ge};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= rem_d;
        val_q[s+1] <= val_d;
        den_q[s+1] <= den_q[s];
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[s+1] <= '0;
      end else if (en_i) begin
        tag_q[s+1] <= tag_q[s];
      end
    end
  end

  // the long quotient of (num<<16)/den holds the cell above the fraction bits
  assign quot_o = val_q[Steps][DivW-1:16];
  assign frac_o = val_q[Steps][15:0];
  assign tag_o  = tag_q[Steps];
endmodule
`default_nettype wire

>>> hdl/heightmap_barycentric_sampler.sv
`default_nettype none
// heightmap barycentric sampler
// in: valid/ready request channel carrying hbs_pkg::req_t. action write stores
// height_value at (grid_row, grid_col) and returns nothing; action query returns
// one hbs_pkg::rsp_t on the out channel with the interpolated Q8.8 height.
// cfg: write port (we, index, data) sets origin_x, origin_z, cell_len; write only
// while idle.
// throughput: one request per cycle unless stalled; all stages move in lock step.
// path: a query passes the offset register, which loads at its accepting edge,
// then the bit-per-stage divider, the four-bank memory read register, and the
// weight multiply, sum and round, and output registers.
// writes go to one of four height banks chosen by row and column parity, so a
// query reads all four corners in one go. a write is issued at the memory
// stage of the pipe, in request order, so later queries see it.
// stall: when the output register holds an unaccepted result the pipe freezes
// and in_ready_o drops. reset clears the valid flags, divider tags and config
// registers; heights are undefined until written.
module heightmap_barycentric_sampler (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire hbs_pkg::req_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output hbs_pkg::rsp_t       out_data_o,
  input  wire logic           cfg_we_i,
  input  wire logic [1:0]     cfg_index_i,
  input  wire logic [31:0]    cfg_data_i
);
  import hbs_pkg::*;

  localparam int unsigned IdxW = $clog2(GridSize);
  localparam int unsigned BankDepth = (GridSize / 2) * (GridSize / 2);
  localparam int unsigned BankAw = $clog2(BankDepth);
  localparam int unsigned NumW = 33;
  // tag: valid, action, write row/col/value
  localparam int unsigned TagW = 2 + 9 + 9 + 8;

  logic signed [31:0] origin_x_q, origin_z_q;
  logic [15:0]        cell_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_z_q <= '0;
      cell_len_q <= 16'(CellLenReset);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ORIGIN_X: origin_x_q <= cfg_data_i;
        REG_ORIGIN_Z: origin_z_q <= cfg_data_i;
        REG_CELL_LEN: cell_len_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // stage 1: offsets
  logic               s1_v_q;
  req_t               s1_q;
  logic signed [33:0] tx_q, tz_q;
  logic [15:0]        len_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q  <= in_data_i;
      tx_q  <= 34'(in_data_i.world_x) - 34'(origin_x_q);
      tz_q  <= 34'(in_data_i.world_z) - 34'(origin_z_q);
      len_q <= (cell_len_q == '0) ? 16'd1 : cell_len_q;
    end
  end

  logic [TagW-1:0] tag_in, tag_x, tag_z;
  logic            neg_x_q, neg_z_q;
  assign tag_in = {s1_v_q, s1_q.action, s1_q.grid_row, s1_q.grid_col, s1_q.height_value};

  // sign flags travel in the tag of the z divider
  logic [NumW-1:0] qx, qz;
  logic [15:0]     fx, fz;
  hbs_divider #(.NumW(NumW), .TagW(TagW)) u_div_x (
    .clk_i, .rst_ni, .en_i(en), .num_i(tx_q[32:0]), .den_i(len_q),
    .tag_i(tag_in), .quot_o(qx), .frac_o(fx), .tag_o(tag_x)
  );
  hbs_divider #(.NumW(NumW), .TagW(2)) u_div_z (
    .clk_i, .rst_ni, .en_i(en), .num_i(tz_q[32:0]), .den_i(len_q),
    .tag_i({tx_q[33], tz_q[33]}), .quot_o(qz), .frac_o(fz), .tag_o({neg_x_q, neg_z_q})
  );
  assign tag_z = tag_x;

  logic       d_v, d_act;
  logic [8:0] d_row, d_col;
  logic [7:0] d_val;
  assign {d_v, d_act, d_row, d_col, d_val} = tag_z;

  logic on_grid;
  assign on_grid = !neg_x_q && !neg_z_q && (qx < NumW'(GridSize - 1))
                   && (qz < NumW'(GridSize - 1));

  // corner coordinates and bank selection
  logic [IdxW-1:0] gx, gz, gx1, gz1;
  assign gx  = qx[IdxW-1:0];
  assign gz  = qz[IdxW-1:0];
  assign gx1 = gx + 1'b1;
  assign gz1 = gz + 1'b1;

  logic [BankAw-1:0] raddr [4];
  logic [7:0]        rdata [4];
  logic              wr_ok;
  logic [BankAw-1:0] waddr;
  logic [1:0]        wbank;
  logic [IdxW-1:0]   wr_r, wr_c;
  assign wr_r  = d_row[IdxW-1:0];
  assign wr_c  = d_col[IdxW-1:0];
  // the 9-bit row and column always lie inside the grid
  assign wr_ok = en && d_v && (d_act == ACT_WRITE);
  assign wbank = {wr_r[0], wr_c[0]};
  assign waddr = BankAw'({wr_r[IdxW-1:1], wr_c[IdxW-1:1]});

  // bank b = {row parity, col parity}; each corner pick the proper row/col
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [IdxW-1:0] r, c;
    always_comb begin
      r = (gx[0] == 1'(b >> 1)) ? gx : gx1;
      c = (gz[0] == 1'(b)) ? gz : gz1;
      raddr[b] = BankAw'({r[IdxW-1:1], c[IdxW-1:1]});
    end
    hbs_ram #(.Width(8), .Depth(BankDepth)) u_ram (
      .clk_i, .we_i(wr_ok && (wbank == 2'(b))), .waddr_i(waddr),
      .wdata_i(d_val), .re_i(en), .raddr_i(raddr[b]), .rdata_o(rdata[b])
    );
  end

  // stage m: memory read
  logic        m_v_q, m_on_q, m_px_q, m_pz_q;
  logic [15:0] m_fx_q, m_fz_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (en) begin
      m_v_q <= d_v && (d_act == ACT_QUERY);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_on_q <= on_grid;
      m_px_q <= gx[0];
      m_pz_q <= gz[0];
      m_fx_q <= fx;
      m_fz_q <= fz;
    end
  end

  logic [7:0] h00, h10, h01, h11;
  assign h00 = rdata[{m_px_q, m_pz_q}];
  assign h10 = rdata[{~m_px_q, m_pz_q}];
  assign h01 = rdata[{m_px_q, ~m_pz_q}];
  assign h11 = rdata[{~m_px_q, ~m_pz_q}];

  logic [17:0] fsum;
  logic        upper;
  logic [16:0] w0, w1, w2;
  logic [7:0]  a0, a1, a2;
  always_comb begin
    fsum  = 18'(m_fx_q) + 18'(m_fz_q);
    upper = fsum > 18'd65536;
    if (upper) begin
      w0 = 17'd65536 - 17'(m_fz_q); a0 = h10;
      w1 = 17'(fsum - 18'd65536);   a1 = h11;
      w2 = 17'd65536 - 17'(m_fx_q); a2 = h01;
    end else begin
      w0 = 17'(18'd65536 - fsum);   a0 = h00;
      w1 = 17'(m_fx_q);             a1 = h10;
      w2 = 17'(m_fz_q);             a2 = h01;
    end
  end

  // stage p: products
  logic        p_v_q, p_on_q;
  logic [24:0] p0_q, p1_q, p2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else if (en) begin
      p_v_q <= m_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_on_q <= m_on_q;
      p0_q   <= w0 * a0;
      p1_q   <= w1 * a1;
      p2_q   <= w2 * a2;
    end
  end

  // stage s: sum and round
  logic        s_v_q, s_on_q;
  logic [26:0] acc_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_v_q <= 1'b0;
    end else if (en) begin
      s_v_q <= p_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s_on_q <= p_on_q;
      acc_q  <= 27'(p0_q) + 27'(p1_q) + 27'(p2_q) + 27'd128;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= s_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_o.on_terrain     <= s_on_q;
      out_data_o.terrain_height <= s_on_q ? acc_q[23:8] : 16'd0;
    end
  end
endmodule
`default_nettype wire
